@@ design/sorted_term_accumulator_macros.svh @@
// ----------------------------------------------------------------------------
// sorted_term_accumulator_macros
// assertion macros of the sorted term accumulator rtl
// ----------------------------------------------------------------------------
`ifndef SORTED_TERM_ACCUMULATOR_MACROS_SVH
`define SORTED_TERM_ACCUMULATOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define STACC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define STACC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/stacc_pkg.sv @@
// ----------------------------------------------------------------------------
// stacc_pkg
// types and constants of the sorted term accumulator
// ----------------------------------------------------------------------------
package stacc_pkg;

  localparam int MAX_TERMS_DEF = 32;
  localparam int COEFF_W       = 32;
  localparam int EXP_W         = 16;
  localparam int TCOEFF_W      = 16;

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_READOUT = 1'b1;

  typedef enum logic [2:0] {
    ST_MERGED     = 3'd0,
    ST_INSERTED   = 3'd1,
    ST_FULL       = 3'd2,
    ST_MERGED_SAT = 3'd3,
    ST_TERM       = 3'd4,
    ST_EMPTY      = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ROTATE
  } cell_op_t;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  typedef struct packed {
    cell_op_t op;
    logic     shift_en;
  } cell_cmd_t;

  typedef struct packed {
    logic signed [TCOEFF_W-1:0] coeff;
    logic signed [EXP_W-1:0]    exponent;
  } key_t;

  typedef struct packed {
    logic signed [COEFF_W-1:0] coeff;
    logic signed [EXP_W-1:0]   exponent;
  } term_t;

  typedef struct packed {
    logic signed [COEFF_W-1:0] coeff;
    logic signed [EXP_W-1:0]   exponent;
    logic                      last;
    status_t                   status;
  } result_t;

endpackage

@@ design/stacc_if.sv @@
// ----------------------------------------------------------------------------
// stacc_if
// valid/ready channels of the sorted term accumulator
// ----------------------------------------------------------------------------
interface stacc_in_if
  import stacc_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic signed [TCOEFF_W-1:0] term_coeff;
  logic signed [EXP_W-1:0]    term_exponent;

  modport source (output valid, operation, term_coeff, term_exponent, input ready);
  modport sink   (input valid, operation, term_coeff, term_exponent, output ready);
endinterface

interface stacc_out_if
  import stacc_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [COEFF_W-1:0] out_coeff;
  logic signed [EXP_W-1:0]   out_exponent;
  logic                      last_term;
  logic [2:0]                status;

  modport source (output valid, out_coeff, out_exponent, last_term, status, input ready);
  modport sink   (input valid, out_coeff, out_exponent, last_term, status, output ready);
endinterface

@@ design/stacc_cell.sv @@
// ----------------------------------------------------------------------------
// stacc_cell
// one slot of the sorted term chain: compare, merge, shift and rotate
// ----------------------------------------------------------------------------
module stacc_cell
  import stacc_pkg::*;
#(
  parameter int MAX_TERMS = MAX_TERMS_DEF,
  parameter int IDX       = 0,
  localparam int CW       = $clog2(MAX_TERMS + 1)
) (
  input  logic            clk,
  input  cell_cmd_t       cmd,
  input  key_t            key,
  input  logic [CW-1:0]   count,
  input  logic            prev_gt,
  input  term_t           prev_term,
  input  term_t           next_term,
  input  term_t           head_term,
  output logic            gt,
  output logic            eq,
  output logic            sat,
  output term_t           term
);

  term_t       term_r;
  term_t       term_nxt;
  logic        valid;
  logic        is_tail;
  logic [32:0] sum;
  logic        ovf;
  logic [31:0] merged;

  assign valid   = count > CW'(IDX);
  assign is_tail = count == CW'(IDX + 1);

  assign gt = valid && ($signed(term_r.exponent) > $signed(key.exponent));
  assign eq = valid && (term_r.exponent == key.exponent);

  // 33-bit sum, overflow when the two top bits differ
  assign sum    = {term_r.coeff[31], term_r.coeff} + {{17{key.coeff[15]}}, key.coeff};
  assign ovf    = sum[32] ^ sum[31];
  assign merged = ovf ? (sum[32] ? 32'h8000_0000 : 32'h7fff_ffff) : sum[31:0];
  assign sat    = eq && ovf;

  always_comb begin
    term_nxt = term_r;
    case (cmd.op)
      CELL_INSERT: begin
        if (eq) begin
          term_nxt.coeff = merged;
        end else if (cmd.shift_en) begin
          if (prev_gt && !gt) begin
            term_nxt.coeff    = {{16{key.coeff[15]}}, key.coeff};
            term_nxt.exponent = key.exponent;
          end else if (!prev_gt) begin
            term_nxt = prev_term;
          end
        end
      end
      CELL_ROTATE: begin
        // tail slot takes the head item, the rest move one toward the head
        term_nxt = is_tail ? head_term : next_term;
      end
      default: begin
        term_nxt = term_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    term_r <= term_nxt;
  end

  assign term = term_r;

endmodule

@@ design/stacc_out_buf.sv @@
// ----------------------------------------------------------------------------
// stacc_out_buf
// two-entry output buffer: output register plus skid register
// ----------------------------------------------------------------------------
module stacc_out_buf
  import stacc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    space,
  output logic    o_valid,
  input  logic    o_ready,
  output result_t o_data
);

  logic    o_valid_r, o_valid_nxt;
  logic    s_valid_r, s_valid_nxt;
  result_t o_data_r,  o_data_nxt;
  result_t s_data_r,  s_data_nxt;
  logic    pop;

  assign pop   = o_valid_r && o_ready;
  assign space = !s_valid_r;

  always_comb begin
    o_valid_nxt = o_valid_r;
    s_valid_nxt = s_valid_r;
    o_data_nxt  = o_data_r;
    s_data_nxt  = s_data_r;
    if (pop || !o_valid_r) begin
      if (s_valid_r) begin
        o_valid_nxt = 1'b1;
        o_data_nxt  = s_data_r;
        s_valid_nxt = 1'b0;
      end else begin
        o_valid_nxt = push;
        o_data_nxt  = push_data;
      end
    end else if (push) begin
      s_valid_nxt = 1'b1;
      s_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
      s_valid_r <= 1'b0;
    end else begin
      o_valid_r <= o_valid_nxt;
      s_valid_r <= s_valid_nxt;
    end
    o_data_r <= o_data_nxt;
    s_data_r <= s_data_nxt;
  end

  assign o_valid = o_valid_r;
  assign o_data  = o_data_r;

endmodule

@@ design/sorted_term_accumulator.sv @@
// ----------------------------------------------------------------------------
// sorted_term_accumulator
// polynomial term table kept sorted by descending exponent in a cell chain
// ----------------------------------------------------------------------------
// in_ch carries one item per handshake: operation 0 adds term_coeff at
// term_exponent (merging with saturation, inserting in sorted place, or dropping the term when the table is full),
// operation 1 reads out the whole table.
// out_ch carries the results; last_term marks the final one of an item.
// An insert gives one status result, registered in the output buffer; a new
// insert can be accepted every cycle while the output buffer has space, as
// all cells compare and shift in parallel.
// A readout of n stored terms keeps in_ch.ready low until its last term is
// pushed: the chain rotates one slot per result, the terms are pushed from
// S_READ one per cycle while the output buffer has space.
// A readout of an empty table gives its one result, pushed on acceptance.
// A two-entry output buffer keeps accepting while one result waits; when
// out_ch stalls and the buffer fills, in_ch.ready drops and rotation pauses.
// Reset empties the table at once (term count cleared, no clearing pass) and
// drops buffered results.
// ----------------------------------------------------------------------------
module sorted_term_accumulator
  import stacc_pkg::*;
#(
  parameter int MAX_TERMS = MAX_TERMS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  stacc_in_if.sink    in_ch,
  stacc_out_if.source out_ch
);

  `include "sorted_term_accumulator_macros.svh"

  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam int IW = $clog2(MAX_TERMS);

  state_t          state_r, state_nxt;
  logic [CW-1:0]   term_count_r, term_count_nxt;
  logic [IW-1:0]   rd_idx_r, rd_idx_nxt;
  logic            in_acc;
  logic            full;
  logic            any_eq;
  logic            any_sat;
  logic            rd_last;
  logic            push;
  logic            space;
  result_t         push_data;
  result_t         o_data;
  cell_cmd_t       cmd;
  key_t            key;
  logic [MAX_TERMS-1:0] gt_vec;
  logic [MAX_TERMS-1:0] eq_vec;
  logic [MAX_TERMS-1:0] sat_vec;
  term_t           terms [MAX_TERMS];

  assign key.coeff    = in_ch.term_coeff;
  assign key.exponent = in_ch.term_exponent;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_TERMS; gi++) begin : g_cell
      stacc_cell #(
        .MAX_TERMS (MAX_TERMS),
        .IDX       (gi)
      ) u_cell (
        .clk       (clk),
        .cmd       (cmd),
        .key       (key),
        .count     (term_count_r),
        .prev_gt   ((gi == 0) ? 1'b1 : gt_vec[(gi == 0) ? 0 : gi - 1]),
        .prev_term (terms[(gi == 0) ? 0 : gi - 1]),
        .next_term (terms[(gi == MAX_TERMS - 1) ? gi : gi + 1]),
        .head_term (terms[0]),
        .gt        (gt_vec[gi]),
        .eq        (eq_vec[gi]),
        .sat       (sat_vec[gi]),
        .term      (terms[gi])
      );
    end
  endgenerate

  assign any_eq   = |eq_vec;
  assign any_sat  = |sat_vec;
  assign full     = term_count_r == CW'(MAX_TERMS);
  assign rd_last  = (CW'(rd_idx_r) + CW'(1)) == term_count_r;
  assign in_ch.ready = (state_r == S_IDLE) && space;
  assign in_acc   = in_ch.valid && in_ch.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_ch.operation == OP_READOUT) && (term_count_r != '0)) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (space && rd_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    push             = 1'b0;
    push_data.coeff    = '0;
    push_data.exponent = '0;
    push_data.last     = 1'b1;
    push_data.status   = ST_INSERTED;
    cmd.op           = CELL_HOLD;
    cmd.shift_en     = 1'b0;
    term_count_nxt   = term_count_r;
    rd_idx_nxt       = rd_idx_r;
    case (state_r)
      S_IDLE: begin
        rd_idx_nxt = '0;
        if (in_acc) begin
          if (in_ch.operation == OP_READOUT) begin
            if (term_count_r == '0) begin
              push             = 1'b1;
              push_data.status = ST_EMPTY;
            end
          end else begin
            push         = 1'b1;
            cmd.op       = CELL_INSERT;
            cmd.shift_en = !any_eq && !full;
            if (any_eq) begin
              push_data.status = any_sat ? ST_MERGED_SAT : ST_MERGED;
            end else if (full) begin
              push_data.status = ST_FULL;
            end else begin
              push_data.status = ST_INSERTED;
              term_count_nxt   = term_count_r + CW'(1);
            end
          end
        end
      end
      S_READ: begin
        if (space) begin
          push               = 1'b1;
          push_data.coeff    = terms[0].coeff;
          push_data.exponent = terms[0].exponent;
          push_data.last     = rd_last;
          push_data.status   = ST_TERM;
          cmd.op             = CELL_ROTATE;
          rd_idx_nxt         = rd_last ? '0 : rd_idx_r + IW'(1);
        end
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      term_count_r <= '0;
      rd_idx_r     <= '0;
    end else begin
      state_r      <= state_nxt;
      term_count_r <= term_count_nxt;
      rd_idx_r     <= rd_idx_nxt;
    end
  end

  stacc_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .space     (space),
    .o_valid   (out_ch.valid),
    .o_ready   (out_ch.ready),
    .o_data    (o_data)
  );

  assign out_ch.out_coeff    = o_data.coeff;
  assign out_ch.out_exponent = o_data.exponent;
  assign out_ch.last_term    = o_data.last;
  assign out_ch.status       = o_data.status;

  `STACC_ASSERT_NOW(a_count_bound, 1'b1, term_count_r <= CW'(MAX_TERMS),
    "term count above table size")
  `STACC_ASSERT_NOW(a_read_nonempty, state_r == S_READ, term_count_r != '0,
    "readout running on an empty table")
  `STACC_ASSERT_NEXT(a_insert_grows, in_acc && cmd.shift_en,
    term_count_r == $past(term_count_r) + CW'(1), "insert did not grow the table")
  `STACC_ASSERT_NEXT(a_read_ends, (state_r == S_READ) && space && rd_last,
    (state_r == S_IDLE) && (rd_idx_r == '0), "readout did not finish on the last term")

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Tests the sorted term accumulator through its item channels. The bench
// predicts the sorted term table, including merges, a full table and
// readouts, and checks every result field against the predicted list.
// Stimulus is a short directed part, random items from a small exponent
// pool, and a final fill of the table, all sent in bursts while the result
// side stalls at random.
// ----------------------------------------------------------------------------
module tb_top
  import stacc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int     TBL_DEPTH      = MAX_TERMS_DEF;
  localparam int     WATCHDOG_LIMIT = 5000;
  localparam int     SETTLE_CYCLES  = 20;
  localparam int     LONG_HOLD      = 300;
  localparam int     HOLD_AT        = 60;
  localparam int     RANDOM_ITEMS   = 160;
  localparam int     POOL_SIZE      = 40;
  localparam longint COEFF_MAX      = 64'sd2147483647;
  localparam longint COEFF_MIN      = -64'sd2147483648;
  localparam int     SAT_HI_EXP     = 777;
  localparam int     SAT_LO_EXP     = -777;

  typedef struct {
    logic                       op;
    logic signed [TCOEFF_W-1:0] coeff;
    logic signed [EXP_W-1:0]    exponent;
    bit                         drain;
  } term_req_t;

  logic clk;
  logic rst_n;

  stacc_in_if  in_ch ();
  stacc_out_if out_ch ();

  sorted_term_accumulator #(
    .MAX_TERMS(TBL_DEPTH)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // predicted term table
  logic signed [EXP_W-1:0]   tbl_exp   [TBL_DEPTH];
  logic signed [COEFF_W-1:0] tbl_coeff [TBL_DEPTH];
  int                        tbl_count = 0;

  term_req_t pending_items [$];
  result_t   pending_results [$];
  int        fail_count = 0;
  int        results_seen = 0;

  task automatic predict_item(input term_req_t rq);
    result_t r;
    int      pos;
    int      k;
    longint  sum;
    r = '0;
    r.last = 1'b1;
    if (rq.op == OP_READOUT) begin
      if (tbl_count == 0) begin
        r.status = ST_EMPTY;
        pending_results.push_back(r);
      end else begin
        for (k = 0; k < tbl_count; k++) begin
          r.coeff    = tbl_coeff[k];
          r.exponent = tbl_exp[k];
          r.last     = (k == tbl_count - 1);
          r.status   = ST_TERM;
          pending_results.push_back(r);
        end
      end
    end else begin
      pos = 0;
      while (pos < tbl_count && tbl_exp[pos] > rq.exponent) pos++;
      if (pos < tbl_count && tbl_exp[pos] == rq.exponent) begin
        sum = longint'(tbl_coeff[pos]) + longint'(rq.coeff);
        r.status = ST_MERGED;
        if (sum > COEFF_MAX) begin
          sum      = COEFF_MAX;
          r.status = ST_MERGED_SAT;
        end else if (sum < COEFF_MIN) begin
          sum      = COEFF_MIN;
          r.status = ST_MERGED_SAT;
        end
        tbl_coeff[pos] = sum[COEFF_W-1:0];
      end else if (tbl_count >= TBL_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        for (k = tbl_count; k > pos; k--) begin
          tbl_exp[k]   = tbl_exp[k-1];
          tbl_coeff[k] = tbl_coeff[k-1];
        end
        tbl_exp[pos]   = rq.exponent;
        tbl_coeff[pos] = COEFF_W'(rq.coeff);
        tbl_count++;
        r.status = ST_INSERTED;
      end
      pending_results.push_back(r);
    end
  endtask

  function automatic void add_item(logic op, int coeff, int expo, bit drain);
    term_req_t rq;
    rq.op       = op;
    rq.coeff    = coeff[TCOEFF_W-1:0];
    rq.exponent = expo[EXP_W-1:0];
    rq.drain    = drain;
    pending_items.push_back(rq);
  endfunction

  // ---------------------------------------------------------------- driver
  term_req_t cur_req;
  bit        offering;
  int        burst_left;
  int        gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      offering   = 1'b0;
      burst_left = $urandom_range(1, 24);
      gap_left   = 0;
      in_ch.valid         <= 1'b0;
      in_ch.operation     <= OP_INSERT;
      in_ch.term_coeff    <= '0;
      in_ch.term_exponent <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_item(cur_req);
        offering = 1'b0;
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0 &&
                     !(pending_items[0].drain && pending_results.size() > 0)) begin
          cur_req  = pending_items.pop_front();
          offering = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
      in_ch.valid         <= offering;
      in_ch.operation     <= cur_req.op;
      in_ch.term_coeff    <= cur_req.coeff;
      in_ch.term_exponent <= cur_req.exponent;
    end
  end

  // -------------------------------------------------------------- receiver
  int rx_tick;
  int rx_mode;
  int hold_left;
  bit hold_done;
  bit rx_ready;

  always @(posedge clk) begin
    if (!rst_n) begin
      rx_tick   = 0;
      rx_mode   = 0;
      hold_left = 0;
      hold_done = 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      if (hold_left > 0) begin
        hold_left--;
        rx_ready = 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        // long hold-off so the output buffer fills and the input stalls
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
        rx_ready  = 1'b0;
      end else begin
        rx_tick++;
        if (rx_tick % 64 == 0) rx_mode = $urandom_range(0, 3);
        case (rx_mode)
          0: rx_ready = 1'b1;
          1: rx_ready = (rx_tick % 3 != 2);
          2: rx_ready = $urandom_range(0, 1);
          default: rx_ready = (rx_tick % 16 < 11);
        endcase
      end
      out_ch.ready <= rx_ready;
    end
  end

  // --------------------------------------------------------------- monitor
  result_t seen_exp;

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with no expectation: coeff %0d exponent %0d status %0d",
               out_ch.out_coeff, out_ch.out_exponent, out_ch.status);
        fail_count++;
      end else begin
        seen_exp = pending_results.pop_front();
        if (out_ch.out_coeff !== seen_exp.coeff) begin
          $error("out_coeff: expected %0d, actual %0d", seen_exp.coeff, out_ch.out_coeff);
          fail_count++;
        end
        if (out_ch.out_exponent !== seen_exp.exponent) begin
          $error("out_exponent: expected %0d, actual %0d",
                 seen_exp.exponent, out_ch.out_exponent);
          fail_count++;
        end
        if (out_ch.last_term !== seen_exp.last) begin
          $error("last_term: expected %0d, actual %0d", seen_exp.last, out_ch.last_term);
          fail_count++;
        end
        if (out_ch.status !== 3'(seen_exp.status)) begin
          $error("status: expected %0d, actual %0d", seen_exp.status, out_ch.status);
          fail_count++;
        end
      end
    end
  end

  // -------------------------------------------------------------- watchdog
  int idle_cycles;

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles = 0;
    end else begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------- stimulus
  int pool [POOL_SIZE];

  initial begin
    rst_n = 1'b0;

    // directed: empty readout, extremes, merges, cancel to zero
    add_item(OP_READOUT, 0, 0, 1'b0);
    add_item(OP_INSERT, 32767, 32767, 1'b0);
    add_item(OP_INSERT, -32768, -32768, 1'b0);
    add_item(OP_INSERT, 0, 0, 1'b0);
    add_item(OP_INSERT, 1, 0, 1'b0);
    add_item(OP_INSERT, -1, 0, 1'b0);
    add_item(OP_INSERT, 5, 100, 1'b0);
    add_item(OP_INSERT, 7, -100, 1'b0);
    add_item(OP_INSERT, 3, 100, 1'b0);
    add_item(OP_INSERT, -32768, 32767, 1'b0);
    add_item(OP_INSERT, 32767, -1, 1'b0);
    add_item(OP_READOUT, -1, -1, 1'b0);

    add_item(OP_INSERT, -1, SAT_HI_EXP, 1'b0);
    add_item(OP_INSERT, 2, SAT_HI_EXP, 1'b0);
    add_item(OP_INSERT, 1, SAT_LO_EXP, 1'b0);
    add_item(OP_READOUT, 0, 0, 1'b0);

    // random part, exponents mostly from a small pool so merges are common
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (i < 2) pool[i] = (i == 0) ? SAT_HI_EXP : SAT_LO_EXP;
      else if (i < 16) pool[i] = $urandom_range(0, 40) - 20;
      else pool[i] = $signed(16'($urandom));
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      int sel;
      int cf;
      sel = $urandom_range(0, 99);
      cf  = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 20) - 10)
                                         : $signed(16'($urandom));
      if (sel < 10) add_item(OP_READOUT, $urandom, $urandom, i == 0);
      else if (sel < 15) add_item(OP_INSERT, cf, $urandom, i == 0);
      else add_item(OP_INSERT, cf, pool[$urandom_range(0, POOL_SIZE - 1)], i == 0);
    end

    // fill whatever room is left, then drop and merge on a full table
    for (int i = 0; i < TBL_DEPTH; i++) add_item(OP_INSERT, i - 16, -20000 + 7 * i, 1'b0);
    add_item(OP_INSERT, 12, 31000, 1'b0);
    add_item(OP_INSERT, 9, 100, 1'b0);
    add_item(OP_READOUT, 0, 0, 1'b0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() > 0 || offering) @(posedge clk);
    while (pending_results.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ sorted_term_accumulator.f @@
+incdir+design
design/stacc_pkg.sv
design/stacc_if.sv
design/stacc_cell.sv
design/stacc_out_buf.sv
design/sorted_term_accumulator.sv
sim/tb_top.sv
